FILE: rtl/hcl_pkg.sv
// Shared constants, types and helper functions of the hex colour line parser.
`timescale 1ns / 1ps
package hcl_pkg;

  // Line geometry
  localparam int LINE_LENGTH = 7;
  localparam int CNT_W       = $clog2(LINE_LENGTH);

  // Job queue geometry
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Result step counter: at most four results per request
  localparam int STEP_W = 2;

  // Character codes
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_F  = 8'h46;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

  localparam logic [23:0] COLOR_RESET = 24'h020202;

  // Result kinds
  localparam logic KIND_ECHO  = 1'b0;
  localparam logic KIND_COLOR = 1'b1;

  // Work handed from the front end to the back end
  typedef enum logic [1:0] {
    JOB_ECHO     = 2'd0,  // echo one character
    JOB_ERASE    = 2'd1,  // echo BS, space, BS
    JOB_LINE_END = 2'd2,  // echo CR, LF, then colour result
    JOB_ECHO_END = 2'd3   // echo character, CR, LF, then colour result
  } job_op_t;

  typedef struct packed {
    job_op_t     op;
    logic [7:0]  ch;
    logic        color_ok;
    logic [23:0] color;
  } job_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       color_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } result_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    if (c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else begin
      d = c - CH_UPPER_A + HEX_LETTER_BASE;
    end
    return d[3:0];
  endfunction

  function automatic result_t echo_result(input logic [7:0] b, input logic lst);
    result_t r;
    r             = '0;
    r.kind        = KIND_ECHO;
    r.tx_byte     = b;
    r.last        = lst;
    return r;
  endfunction

  function automatic result_t color_result(input job_t j);
    result_t r;
    r             = '0;
    r.kind        = KIND_COLOR;
    r.color_valid = j.color_ok;
    r.red         = j.color[23:16];
    r.green       = j.color[15:8];
    r.blue        = j.color[7:0];
    r.last        = 1'b1;
    return r;
  endfunction

  // Result number 'step' of a job
  function automatic result_t job_result(input job_t j, input logic [STEP_W-1:0] step);
    result_t r;
    r = '0;
    case (j.op)
      JOB_ECHO: begin
        r = echo_result(j.ch, 1'b1);
      end
      JOB_ERASE: begin
        case (step)
          2'd0:    r = echo_result(CH_BS, 1'b0);
          2'd1:    r = echo_result(CH_SPACE, 1'b0);
          default: r = echo_result(CH_BS, 1'b1);
        endcase
      end
      JOB_LINE_END: begin
        case (step)
          2'd0:    r = echo_result(CH_CR, 1'b0);
          2'd1:    r = echo_result(CH_LF, 1'b0);
          default: r = color_result(j);
        endcase
      end
      JOB_ECHO_END: begin
        case (step)
          2'd0:    r = echo_result(j.ch, 1'b0);
          2'd1:    r = echo_result(CH_CR, 1'b0);
          2'd2:    r = echo_result(CH_LF, 1'b0);
          default: r = color_result(j);
        endcase
      end
      default: r = echo_result(j.ch, 1'b1);
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/hcl_ifs.sv
// Request and result channel interfaces of the hex colour line parser.
`timescale 1ns / 1ps
interface hcl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hcl_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic       color_valid;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last;

  modport source (output valid, output kind, output tx_byte, output color_valid,
                  output red, output green, output blue, output last, input ready);
  modport sink   (input valid, input kind, input tx_byte, input color_valid,
                  input red, input green, input blue, input last, output ready);
endinterface

FILE: rtl/hex_color_line_parser.sv
// A request goes into the job queue, then into the back end's current job register,
// and its first result is registered into the output register. Results leave one per
// cycle unless out_ready stalls; requests give 1, 3 or 4 results, ignored erases none.
// A two-entry job queue lets requests be taken while results still wait to drain.
// Reset (rst_n low, synchronous): empties the line, queue and output register and sets
// the held colour to 0x020202; the line store itself is not cleared.
`timescale 1ns / 1ps
module hex_color_line_parser (
  input  logic clk,
  input  logic rst_n,
  hcl_in_if.sink    in_ch,
  hcl_out_if.source out_ch
);

  hcl_pkg::q_status_t q_status;
  hcl_pkg::job_t      push_job;
  hcl_pkg::job_t      pop_job;
  hcl_pkg::result_t   result;
  logic               push;
  logic               pop;
  logic               in_ready;
  logic               out_valid;

  hcl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_ch.rx_byte),
    .q_status   (q_status),
    .q_push     (push),
    .q_job      (push_job)
  );

  hcl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  hcl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .q_job      (pop_job),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_result (result)
  );

  // Drive the channels
  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.kind        = result.kind;
  assign out_ch.tx_byte     = result.tx_byte;
  assign out_ch.color_valid = result.color_valid;
  assign out_ch.red         = result.red;
  assign out_ch.green       = result.green;
  assign out_ch.blue        = result.blue;
  assign out_ch.last        = result.last;

endmodule

FILE: rtl/hcl_front.sv
// Front end: accepts received bytes, edits the line and issues jobs.
`timescale 1ns / 1ps
module hcl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  input  hcl_pkg::q_status_t  q_status,
  output logic                q_push,
  output hcl_pkg::job_t       q_job
);

  logic [7:0]                 line_store [hcl_pkg::LINE_LENGTH];
  logic [hcl_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [23:0]                held_color_r, held_color_nxt;
  logic [7:0]                 ch_up;
  logic                       accept;
  logic                       is_cr;
  logic                       is_erase;
  logic                       store_char;
  logic                       line_full;
  logic                       line_ok;
  logic [23:0]                new_color;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // Classify the request
  always_comb begin
    ch_up = in_rx_byte;
    if ((in_rx_byte >= hcl_pkg::CH_LOWER_A) && (in_rx_byte <= hcl_pkg::CH_LOWER_Z)) begin
      ch_up = in_rx_byte - hcl_pkg::CASE_OFFSET;
    end
  end

  assign is_cr      = (in_rx_byte == hcl_pkg::CH_CR);
  assign is_erase   = (in_rx_byte == hcl_pkg::CH_BS) || (in_rx_byte == hcl_pkg::CH_DEL);
  assign store_char = !is_cr && !is_erase;
  assign line_full  = (count_r == hcl_pkg::CNT_W'(hcl_pkg::LINE_LENGTH - 1));

  // Check the line formed by the stored characters and the incoming last one
  always_comb begin
    line_ok   = (line_store[0] == hcl_pkg::CH_HASH) && hcl_pkg::is_hex(ch_up);
    new_color = '0;
    for (int i = 1; i < hcl_pkg::LINE_LENGTH - 1; i++) begin
      line_ok   = line_ok && hcl_pkg::is_hex(line_store[i]);
      new_color = {new_color[19:0], hcl_pkg::hex_val(line_store[i])};
    end
    new_color = {new_color[19:0], hcl_pkg::hex_val(ch_up)};
  end

  // Build the job and the next line state
  always_comb begin
    count_nxt      = count_r;
    held_color_nxt = held_color_r;
    q_push         = 1'b0;
    q_job.op       = hcl_pkg::JOB_ECHO;
    q_job.ch       = ch_up;
    q_job.color_ok = 1'b0;
    q_job.color    = held_color_r;
    if (accept) begin
      if (is_cr) begin
        q_push    = 1'b1;
        q_job.op  = hcl_pkg::JOB_LINE_END;
        count_nxt = '0;
      end else if (is_erase) begin
        if (count_r != '0) begin
          q_push    = 1'b1;
          q_job.op  = hcl_pkg::JOB_ERASE;
          count_nxt = count_r - 1'b1;
        end
      end else if (line_full) begin
        q_push         = 1'b1;
        q_job.op       = hcl_pkg::JOB_ECHO_END;
        q_job.color_ok = line_ok;
        count_nxt      = '0;
        if (line_ok) begin
          held_color_nxt = new_color;
          q_job.color    = new_color;
        end
      end else begin
        q_push    = 1'b1;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // Store the character at the end of the line
  always_ff @(posedge clk) begin
    if (accept && store_char) begin
      line_store[count_r] <= ch_up;
    end
  end

  // Hold count and colour
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      held_color_r <= hcl_pkg::COLOR_RESET;
    end else begin
      count_r      <= count_nxt;
      held_color_r <= held_color_nxt;
    end
  end

endmodule

FILE: rtl/hcl_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
module hcl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hcl_pkg::job_t      push_job,
  input  logic               pop,
  output hcl_pkg::job_t      pop_job,
  output hcl_pkg::q_status_t status
);

  hcl_pkg::job_t                 slots [hcl_pkg::Q_DEPTH];
  logic [hcl_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [hcl_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [hcl_pkg::Q_CNT_W-1:0]   fill_r, fill_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign status.valid = (fill_r != '0);
  assign status.full  = (fill_r == hcl_pkg::Q_CNT_W'(hcl_pkg::Q_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign pop_job      = slots[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == hcl_pkg::Q_PTR_W'(hcl_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == hcl_pkg::Q_PTR_W'(hcl_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  // Write the incoming job
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

FILE: rtl/hcl_back.sv
// Back end: expands each job into its results, one per cycle unless out_ready stalls, into the output register.
`timescale 1ns / 1ps
module hcl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  hcl_pkg::q_status_t q_status,
  input  hcl_pkg::job_t      q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output hcl_pkg::result_t   out_result
);

  hcl_pkg::job_t               cur_r, cur_nxt;
  logic                        cur_valid_r, cur_valid_nxt;
  logic [hcl_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;
  hcl_pkg::result_t            out_r, out_nxt;
  hcl_pkg::result_t            res;
  logic                        slot_free;
  logic                        load;
  logic                        job_done;

  assign res       = hcl_pkg::job_result(cur_r, step_r);
  assign slot_free = !out_valid_r || out_ready;
  assign load      = slot_free && cur_valid_r;
  assign job_done  = load && res.last;
  assign q_pop     = q_status.valid && (!cur_valid_r || job_done);

  // Issue the next result and take the next job
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (slot_free) begin
      out_valid_nxt = cur_valid_r;
    end
    if (load) begin
      out_nxt  = res;
      step_nxt = step_r + 1'b1;
    end
    if (job_done) begin
      cur_valid_nxt = 1'b0;
      step_nxt      = '0;
    end
    if (q_pop) begin
      cur_nxt       = q_job;
      cur_valid_nxt = 1'b1;
      step_nxt      = '0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

FILE: rtl/hcl_checker.sv
// Port-level checks of the hex colour line parser and their binding.
`timescale 1ns / 1ps
module hcl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] out_tx_byte,
  input logic       out_color_valid,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_last
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Echo results carry no colour
  a_echo_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == hcl_pkg::KIND_ECHO) |->
      !out_color_valid && (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0))
    else $error("echo result carries colour fields");

  // A colour result closes its request and has no transmit byte
  a_color_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == hcl_pkg::KIND_COLOR) |-> out_last && (out_tx_byte == 8'd0))
    else $error("colour result not final or has transmit byte");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind hex_color_line_parser hcl_checker u_hcl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_tx_byte     (out_ch.tx_byte),
  .out_color_valid (out_ch.color_valid),
  .out_red         (out_ch.red),
  .out_green       (out_ch.green),
  .out_blue        (out_ch.blue),
  .out_last        (out_ch.last)
);

FILE: verif/hcl_line_checker.sv
// Checker for the hex colour line parser: line editor prediction and result comparison.
`timescale 1ns / 1ps
module hcl_line_checker
  import hcl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  hcl_in_if    in_mon,
  hcl_out_if   out_mon,
  output int   mismatch_count,
  output int   pending_results
);

  // Predicted line and colour state
  logic [7:0]  line_chars [LINE_LENGTH];
  int          line_len;
  logic [23:0] held_rgb;
  result_t     expected_echoes [$];
  int          fail_total = 0;
  int          queued     = 0;

  assign mismatch_count  = fail_total;
  assign pending_results = queued;

  function automatic string show(input result_t r);
    return $sformatf("kind=%0d tx=%02h ok=%0d rgb=%02h%02h%02h last=%0d",
                     r.kind, r.tx_byte, r.color_valid, r.red, r.green, r.blue, r.last);
  endfunction

  task automatic push_echo(input logic [7:0] ch, input logic lst);
    result_t r;
    r         = '0;
    r.kind    = KIND_ECHO;
    r.tx_byte = ch;
    r.last    = lst;
    expected_echoes.push_back(r);
  endtask

  // Echo CR LF, decode #RRGGBB and queue the colour result
  task automatic close_line();
    logic        ok;
    logic [23:0] rgb;
    logic [7:0]  c;
    logic [3:0]  nib;
    result_t     r;
    ok  = (line_len == LINE_LENGTH) && (line_chars[0] == CH_HASH);
    rgb = '0;
    for (int i = 1; i < LINE_LENGTH; i++) begin
      if (ok) begin
        c = line_chars[i];
        if (c >= CH_ZERO && c <= CH_NINE) begin
          nib = 4'(c - CH_ZERO);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
          nib = 4'(c - CH_UPPER_A) + 4'd10;
        end else begin
          ok  = 1'b0;
          nib = '0;
        end
        rgb = {rgb[19:0], nib};
      end
    end
    if (ok) held_rgb = rgb;
    push_echo(CH_CR, 1'b0);
    push_echo(CH_LF, 1'b0);
    r             = '0;
    r.kind        = KIND_COLOR;
    r.color_valid = ok;
    r.red         = held_rgb[23:16];
    r.green       = held_rgb[15:8];
    r.blue        = held_rgb[7:0];
    r.last        = 1'b1;
    expected_echoes.push_back(r);
    line_len = 0;
  endtask

  // Edit the line with one request and queue what it should echo
  task automatic apply_rx(input logic [7:0] rx);
    logic [7:0] ch;
    ch = rx;
    if (ch == CH_CR) begin
      close_line();
    end else if (ch == CH_BS || ch == CH_DEL) begin
      // erase on an empty line gives nothing
      if (line_len > 0) begin
        line_len--;
        push_echo(CH_BS, 1'b0);
        push_echo(CH_SPACE, 1'b0);
        push_echo(CH_BS, 1'b1);
      end
    end else begin
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ch = ch - CASE_OFFSET;
      line_chars[line_len] = ch;
      line_len++;
      if (line_len == LINE_LENGTH) begin
        push_echo(ch, 1'b0);
        close_line();
      end else begin
        push_echo(ch, 1'b1);
      end
    end
  endtask

  // Compare results first: no result can stem from a request taken at the same edge
  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (!rst_n) begin
      expected_echoes.delete();
      line_len = 0;
      held_rgb = COLOR_RESET;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.kind        = out_mon.kind;
        got.tx_byte     = out_mon.tx_byte;
        got.color_valid = out_mon.color_valid;
        got.red         = out_mon.red;
        got.green       = out_mon.green;
        got.blue        = out_mon.blue;
        got.last        = out_mon.last;
        if (expected_echoes.size() == 0) begin
          fail_total++;
          if (fail_total <= 10) $display("%0t: unexpected result %s", $realtime, show(got));
        end else begin
          want = expected_echoes.pop_front();
          if (got !== want) begin
            fail_total++;
            if (fail_total <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) apply_rx(in_mon.rx_byte);
    end
    queued = expected_echoes.size();
  end

endmodule

FILE: verif/tb_top.sv
// Top of the hex colour line parser testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import hcl_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   steady_flow;
  int   line_fill;
  int   items_sent;
  int   random_start;

  hcl_in_if  in_ch ();
  hcl_out_if out_ch ();

  hex_color_line_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hcl_line_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatch_count  (fail_count),
    .pending_results (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Give up well past the slowest legal run
  initial begin
    #15_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly short gaps, a few long ones, none while flow is steady
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: stall at random
  initial begin
    int stall_left;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady_flow && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v - 10);
  endfunction

  // Any byte that is stored rather than acted on
  function automatic logic [7:0] stray_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_CR || c == CH_BS || c == CH_DEL);
    return c;
  endfunction

  function automatic logic [7:0] erase_char();
    return $urandom_range(0, 1) ? CH_BS : CH_DEL;
  endfunction

  // Offer one request at a falling edge, hold until taken, then idle at random
  task automatic send_char(input logic [7:0] ch);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (ch == CH_CR) begin
      line_fill = 0;
      items_sent++;
    end else if (ch == CH_BS || ch == CH_DEL) begin
      if (line_fill > 0) begin
        line_fill--;
        items_sent++;
      end
    end else begin
      line_fill = (line_fill == LINE_LENGTH - 1) ? 0 : line_fill + 1;
      items_sent++;
    end
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= 8'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drop valid and wait for every queued result
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
  endtask

  // One line of random shape: about half well-formed colours, the rest broken or noise
  task automatic send_random_line();
    int         shape;
    int         n;
    int         slip;
    logic [7:0] ch;
    shape = $urandom_range(0, 99);
    if (shape < 80 && line_fill != 0) send_char(CH_CR);
    if (shape < 50) begin
      send_char(CH_HASH);
      for (int i = 1; i < LINE_LENGTH; i++) begin
        // typing slip erased again, never on the closing character
        if (i < LINE_LENGTH - 1 && $urandom_range(0, 7) == 0) begin
          send_char(stray_char());
          send_char(erase_char());
        end
        send_char(hex_char());
      end
    end else if (shape < 65) begin
      slip = $urandom_range(0, LINE_LENGTH - 1);
      for (int i = 0; i < LINE_LENGTH; i++) begin
        ch = (i == 0) ? CH_HASH : hex_char();
        if (i == slip) ch = stray_char();
        send_char(ch);
      end
    end else if (shape < 80) begin
      n = $urandom_range(0, LINE_LENGTH - 1);
      for (int i = 0; i < n; i++) begin
        if (i == 0 && $urandom_range(0, 3) != 0) send_char(CH_HASH);
        else send_char($urandom_range(0, 3) != 0 ? hex_char() : stray_char());
      end
      send_char(CH_CR);
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) send_char(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    rst_n         = 1'b0;
    steady_flow   = 1'b0;
    line_fill     = 0;
    items_sent    = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: erase and CR on an empty line
    send_char(CH_DEL);
    send_char(CH_BS);
    send_char(CH_CR);
    // lowercase colour closed by its seventh character
    send_text("#ffffff");
    // erase of a bad byte, then the lowest colour
    send_text("#00");
    send_char(8'hFF);
    send_char(CH_DEL);
    send_text("0000");
    // short line leaves the colour alone
    send_text("#a");
    send_char(CH_CR);
    // seven characters with zero and neighbours of the hex ranges
    send_char(CH_HASH);
    send_char(8'h00);
    send_text("9:@/g");
    hold_until_drained();

    // Random lines, with steady stretches and occasional full drains
    random_start = items_sent;
    while (items_sent - random_start < 470) begin
      if ($urandom_range(0, 19) == 0) steady_flow = !steady_flow;
      send_random_line();
      if ($urandom_range(0, 39) == 0) hold_until_drained();
    end
    steady_flow = 1'b0;

    hold_until_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
